/* hw/rtl/i2cbm_pkg.sv */
// Shared types, codes and helpers for the I2C byte master.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2cbm_pkg;

	localparam int TIMER_W = 16;
	localparam int CFG_W = 16;
	localparam int WIDE_W = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;
	localparam logic [WIDE_W-1:0] TIMER_MAX = WIDE_W'((64'd1 << TIMER_W) - 64'd1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCL_LOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCL_HIGH = 1'd1;
	localparam logic [CFG_W-1:0] SCL_TICKS_RST = CFG_W'(5);

	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ = 3'd4;

	localparam logic [1:0] CLS_TICK = 2'd0;
	localparam logic [1:0] CLS_CMD = 2'd1;
	localparam logic [1:0] CLS_NONE = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [6:0] target_address;
		logic       read_direction;
		logic [7:0] write_value;
		logic       send_ack;
		logic       scl_sample;
		logic       sda_sample;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       acked;
		logic [7:0] read_value;
		logic       rejected;
	} res_item_t;

	typedef struct packed {
		logic [1:0] cls;
		logic [2:0] cmd;
		logic [7:0] data;
		logic       ack;
		logic       scl;
		logic       sda;
	} q_entry_t;

	function automatic logic [TIMER_W-1:0] clamp_ticks(input logic [CFG_W-1:0] v);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		if (w == '0) w = WIDE_W'(1);
		if (w > TIMER_MAX) w = TIMER_MAX;
		return w[TIMER_W-1:0];
	endfunction

endpackage

/* hw/rtl/i2cbm_front.sv */
// Front end: classifies incoming items into queue entries.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_front (
	input  i2cbm_pkg::cmd_item_t item,
	output i2cbm_pkg::q_entry_t  entry
);
	import i2cbm_pkg::*;

	always_comb begin
		entry.cmd  = item.action;
		entry.scl  = item.scl_sample;
		entry.sda  = item.sda_sample;
		entry.data = '0;
		entry.ack  = 1'b0;
		case (item.action)
			ACT_TICK: begin
				entry.cls = CLS_TICK;
			end
			ACT_START: begin
				entry.cls  = CLS_CMD;
				entry.data = {item.target_address, item.read_direction};
			end
			ACT_STOP: begin
				entry.cls = CLS_CMD;
			end
			ACT_WRITE: begin
				entry.cls  = CLS_CMD;
				entry.data = item.write_value;
			end
			ACT_READ: begin
				entry.cls = CLS_CMD;
				entry.ack = item.send_ack;
			end
			default: begin
				entry.cls = CLS_NONE;
			end
		endcase
	end

endmodule

/* hw/rtl/i2cbm_queue.sv */
// Short flop queue between the front end and the bus engine.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  i2cbm_pkg::q_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                avail,
	output i2cbm_pkg::q_entry_t head
);
	import i2cbm_pkg::*;

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> (count_q != '0))
		else $error("queue popped while empty");

endmodule

/* hw/rtl/i2cbm_engine.sv */
// Bus engine: timing registers, bit sequencer and result register.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [i2cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i2cbm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                 q_avail,
	input  i2cbm_pkg::q_entry_t                  q_head,
	output logic                                 q_pop,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output i2cbm_pkg::res_item_t                 res_item
);
	import i2cbm_pkg::*;

	localparam logic [3:0] PH_IDLE          = 4'd0;
	localparam logic [3:0] PH_PRE_REL_WAIT  = 4'd1;
	localparam logic [3:0] PH_PRE_REL_HOLD  = 4'd2;
	localparam logic [3:0] PH_PRE_BUS_IDLE  = 4'd3;
	localparam logic [3:0] PH_PRE_SDA_WAIT  = 4'd4;
	localparam logic [3:0] PH_PRE_SDA_HOLD  = 4'd5;
	localparam logic [3:0] PH_PRE_LOW       = 4'd6;
	localparam logic [3:0] PH_BIT_SETUP     = 4'd7;
	localparam logic [3:0] PH_BIT_WAIT      = 4'd8;
	localparam logic [3:0] PH_BIT_HOLD      = 4'd9;
	localparam logic [3:0] PH_BIT_LOW       = 4'd10;
	localparam logic [3:0] PH_STOP_LOW      = 4'd11;
	localparam logic [3:0] PH_STOP_WAIT     = 4'd12;
	localparam logic [3:0] PH_STOP_HOLD     = 4'd13;
	localparam logic [3:0] PH_STOP_REL_WAIT = 4'd14;
	localparam logic [3:0] PH_STOP_REL_HOLD = 4'd15;

	localparam logic [3:0] BC_ACK = 4'd8;
	localparam logic [TIMER_W-1:0] ONE_TICK = TIMER_W'(1);

	logic [CFG_W-1:0]   low_ticks_q;
	logic [CFG_W-1:0]   high_ticks_q;
	logic [3:0]         phase_q, n_phase;
	logic [3:0]         bc_q, n_bc;
	logic [7:0]         shift_q, n_shift;
	logic [TIMER_W-1:0] dc_q, n_dc;
	logic [2:0]         cmd_q, n_cmd;
	logic               ack_q, n_ack;
	logic               scl_q, n_scl;
	logic               sda_q, n_sda;
	logic               res_valid_q;
	res_item_t          res_q, res_d;

	logic [TIMER_W-1:0] lo, hi, dc_dec;
	logic               cnt_done, rd, take;

	function automatic logic slot_sda(input logic is_rd, input logic ack_slot,
			input logic msb, input logic ack);
		if (!ack_slot) return is_rd ? 1'b1 : msb;
		return is_rd ? !ack : 1'b1;
	endfunction

	assign lo       = clamp_ticks(low_ticks_q);
	assign hi       = clamp_ticks(high_ticks_q);
	assign dc_dec   = (dc_q != '0) ? dc_q - ONE_TICK : dc_q;
	assign cnt_done = (dc_dec == '0);
	assign rd       = (cmd_q == ACT_READ);
	assign take     = q_avail && (!res_valid_q || res_ready);
	assign q_pop    = take;

	always_comb begin
		n_phase = phase_q;
		n_bc    = bc_q;
		n_shift = shift_q;
		n_dc    = dc_q;
		n_cmd   = cmd_q;
		n_ack   = ack_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		res_d   = '0;
		case (q_head.cls)
			CLS_TICK: begin
				case (phase_q)
					PH_PRE_REL_WAIT: begin
						if (q_head.scl) begin
							n_phase = PH_PRE_REL_HOLD; n_scl = 1'b1; n_sda = 1'b1; n_dc = hi;
						end
					end
					PH_PRE_REL_HOLD: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							n_phase = PH_PRE_BUS_IDLE; n_scl = 1'b1; n_sda = 1'b1; n_dc = '0;
						end
					end
					PH_PRE_BUS_IDLE: begin
						if (q_head.scl && q_head.sda) begin
							n_phase = PH_PRE_SDA_WAIT; n_scl = 1'b1; n_sda = 1'b0; n_dc = '0;
						end
					end
					PH_PRE_SDA_WAIT: begin
						if (q_head.scl) begin
							n_phase = PH_PRE_SDA_HOLD; n_scl = 1'b1; n_sda = 1'b0; n_dc = hi;
						end
					end
					PH_PRE_SDA_HOLD: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							n_phase = PH_PRE_LOW; n_scl = 1'b0; n_sda = 1'b0; n_dc = lo;
						end
					end
					PH_PRE_LOW: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							n_bc    = '0;
							n_phase = PH_BIT_SETUP;
							n_scl   = 1'b0;
							n_sda   = slot_sda(rd, 1'b0, shift_q[7], ack_q);
							n_dc    = ONE_TICK;
						end
					end
					PH_BIT_SETUP: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							n_phase = PH_BIT_WAIT; n_scl = 1'b1; n_dc = '0;
						end
					end
					PH_BIT_WAIT: begin
						if (q_head.scl) begin
							n_phase = PH_BIT_HOLD; n_scl = 1'b1; n_dc = hi;
						end
					end
					PH_BIT_HOLD: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							if (bc_q != BC_ACK) n_shift = {shift_q[6:0], rd & q_head.sda};
							else if (!rd) n_shift = {7'd0, !q_head.sda};
							n_phase = PH_BIT_LOW; n_scl = 1'b0; n_dc = lo;
						end
					end
					PH_BIT_LOW: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							if (bc_q == BC_ACK) begin
								n_phase        = PH_IDLE;
								n_dc           = '0;
								res_d.done_res = 1'b1;
								if (rd) res_d.read_value = shift_q;
								else if (cmd_q != ACT_STOP) res_d.acked = shift_q[0];
							end else begin
								n_bc    = bc_q + 4'd1;
								n_phase = PH_BIT_SETUP;
								n_scl   = 1'b0;
								n_sda   = slot_sda(rd, bc_q == BC_ACK - 4'd1, shift_q[7], ack_q);
								n_dc    = ONE_TICK;
							end
						end
					end
					PH_STOP_LOW: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							n_phase = PH_STOP_WAIT; n_scl = 1'b1; n_sda = 1'b0; n_dc = '0;
						end
					end
					PH_STOP_WAIT: begin
						if (q_head.scl) begin
							n_phase = PH_STOP_HOLD; n_scl = 1'b1; n_sda = 1'b0; n_dc = hi;
						end
					end
					PH_STOP_HOLD: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							n_phase = PH_STOP_REL_WAIT; n_scl = 1'b1; n_sda = 1'b1; n_dc = '0;
						end
					end
					PH_STOP_REL_WAIT: begin
						if (q_head.scl) begin
							n_phase = PH_STOP_REL_HOLD; n_scl = 1'b1; n_sda = 1'b1; n_dc = hi;
						end
					end
					PH_STOP_REL_HOLD: begin
						n_dc = dc_dec;
						if (cnt_done) begin
							n_phase        = PH_IDLE;
							n_dc           = '0;
							res_d.done_res = 1'b1;
							if (rd) res_d.read_value = shift_q;
							else if (cmd_q != ACT_STOP) res_d.acked = shift_q[0];
						end
					end
					default: begin
						n_phase = PH_IDLE;
					end
				endcase
			end
			CLS_CMD: begin
				if (phase_q != PH_IDLE) begin
					res_d.rejected = 1'b1;
				end else begin
					n_cmd = q_head.cmd;
					n_bc  = '0;
					case (q_head.cmd)
						ACT_START: begin
							n_shift = q_head.data;
							n_phase = PH_PRE_REL_WAIT; n_scl = 1'b1; n_sda = 1'b1; n_dc = '0;
						end
						ACT_STOP: begin
							n_phase = PH_STOP_LOW; n_scl = 1'b0; n_sda = 1'b0; n_dc = lo;
						end
						default: begin
							n_shift = q_head.data;
							n_ack   = q_head.ack;
							n_phase = PH_BIT_SETUP;
							n_scl   = 1'b0;
							n_sda   = slot_sda(q_head.cmd == ACT_READ, 1'b0, q_head.data[7],
								q_head.ack);
							n_dc    = ONE_TICK;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		res_d.scl_release = n_scl;
		res_d.sda_release = n_sda;
		res_d.busy_res    = (n_phase != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_ticks_q  <= SCL_TICKS_RST;
			high_ticks_q <= SCL_TICKS_RST;
			phase_q      <= PH_IDLE;
			bc_q         <= '0;
			shift_q      <= '0;
			dc_q         <= '0;
			cmd_q        <= ACT_TICK;
			ack_q        <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_SCL_LOW) low_ticks_q <= cfg_data;
			if (cfg_we && cfg_index == REG_SCL_HIGH) high_ticks_q <= cfg_data;
			if (take) begin
				phase_q <= n_phase;
				bc_q    <= n_bc;
				shift_q <= n_shift;
				dc_q    <= n_dc;
				cmd_q   <= n_cmd;
				ack_q   <= n_ack;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
			end
			if (take) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_d.done_res) |=> (phase_q == PH_IDLE))
		else $error("command finished but engine not idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_d.rejected) |-> (phase_q != PH_IDLE))
		else $error("command rejected while idle");
	assert property (@(posedge clk) disable iff (!arst_n) bc_q <= BC_ACK)
		else $error("bit counter past acknowledge slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (dc_q == '0))
		else $error("timer running while idle");

endmodule

/* hw/rtl/i2c_byte_master_unit.sv */
// Top level of the I2C byte master: front end, queue and bus engine.
// Depends on i2cbm_pkg, i2cbm_front, i2cbm_queue and i2cbm_engine.
//
// Usage: every item on the cmd channel is either a tick carrying the
// sampled SCL and SDA levels, or a command (start with address, stop,
// write byte, read byte). Each accepted item yields exactly one item on
// the res channel with the pin drives and status. Commands issued while
// a previous command is still running come back with rejected set.
// The cfg port sets SCL low and high times in ticks; write it only when
// the block is idle. A zero value counts as one tick.
// Throughput: one item per cycle (single-step engine) unless res_ready stalls.
// Each item is registered in the queue, and its result in the engine's
// result register. A four-entry queue sits between front end and
// engine, so the input keeps taking items while a result waits;
// cmd_ready falls once the queue is full and the result register is
// stalled.
// Reset: both lines released, engine idle, timing registers back to 5.
`timescale 1ns / 1ps

module i2c_byte_master_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [i2cbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cbm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  i2cbm_pkg::cmd_item_t            cmd_item,
	output logic                            res_valid,
	input  logic                            res_ready,
	output i2cbm_pkg::res_item_t            res_item
);
	import i2cbm_pkg::*;

	q_entry_t front_entry;
	q_entry_t q_head;
	logic     q_full;
	logic     q_avail;
	logic     q_pop;
	logic     q_push;

	assign cmd_ready = !q_full;
	assign q_push    = cmd_valid && cmd_ready;

	i2cbm_front u_front (
		.item  (cmd_item),
		.entry (front_entry)
	);

	i2cbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.avail      (q_avail),
		.head       (q_head)
	);

	i2cbm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_avail   (q_avail),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

/* tb/tb.sv */
// Self-checking testbench for i2c_byte_master_unit: drives tick and command transfers,
// predicts every status result with its own I2C bus-engine model and compares them.
// Depends on i2cbm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
	import i2cbm_pkg::*;

	localparam int ACT_FIRST_UNUSED = 5;
	localparam int ACT_LAST = 7;
	localparam int RANDOM_ITEMS = 1200;
	localparam logic [CFG_W-1:0] TICKS_LONG = CFG_W'(100);

	typedef enum logic [4:0] {
		PH_IDLE, PH_PRE_REL_WAIT, PH_PRE_REL_HOLD, PH_PRE_BUS_IDLE, PH_PRE_SDA_WAIT,
		PH_PRE_SDA_HOLD, PH_PRE_LOW, PH_BIT_SETUP, PH_BIT_WAIT, PH_BIT_HOLD, PH_BIT_LOW,
		PH_STOP_LOW, PH_STOP_WAIT, PH_STOP_HOLD, PH_STOP_REL_WAIT, PH_STOP_REL_HOLD
	} bus_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_item_t cmd_item = '0;
	logic res_valid;
	logic res_ready = 1'b1;
	res_item_t res_item;

	// bus engine model state
	bus_phase_t ph = PH_IDLE;
	logic [3:0] bit_cnt = '0;
	logic [7:0] shreg = '0;
	logic [15:0] dly = '0;
	logic [2:0] cur_cmd = ACT_TICK;
	logic ack_out = 1'b0;
	logic scl_drv = 1'b1;
	logic sda_drv = 1'b1;
	logic [CFG_W-1:0] low_ticks = SCL_TICKS_RST;
	logic [CFG_W-1:0] high_ticks = SCL_TICKS_RST;

	res_item_t pending_status[$];
	res_item_t want;
	int err_cnt = 0;
	int item_cnt = 0;
	int res_stall_cnt = 0;
	bit quiet = 1'b0;

	i2c_byte_master_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_item(cmd_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item)
	);

	always #6 clk = ~clk;

	function automatic logic [15:0] eff_ticks(logic [CFG_W-1:0] v);
		return (v == '0) ? 16'd1 : v;
	endfunction

	function automatic void enter(bus_phase_t p, logic scl, logic sda, logic [15:0] d);
		ph = p;
		scl_drv = scl;
		sda_drv = sda;
		dly = d;
	endfunction

	function automatic logic slot_sda();
		if (bit_cnt < 4'd8)
			return (cur_cmd == ACT_READ) ? 1'b1 : shreg[7];
		return (cur_cmd == ACT_READ) ? ~ack_out : 1'b1;
	endfunction

	function automatic bit count_out();
		if (dly != '0)
			dly = dly - 16'd1;
		return dly == '0;
	endfunction

	function automatic bit bus_advance(logic scl, logic sda);
		logic [15:0] lo;
		logic [15:0] hi;
		bit rd;
		bit fin;
		lo = eff_ticks(low_ticks);
		hi = eff_ticks(high_ticks);
		rd = (cur_cmd == ACT_READ);
		fin = 1'b0;
		case (ph)
			PH_PRE_REL_WAIT: if (scl) enter(PH_PRE_REL_HOLD, 1'b1, 1'b1, hi);
			PH_PRE_REL_HOLD: if (count_out()) enter(PH_PRE_BUS_IDLE, 1'b1, 1'b1, '0);
			PH_PRE_BUS_IDLE: if (scl && sda) enter(PH_PRE_SDA_WAIT, 1'b1, 1'b0, '0);
			PH_PRE_SDA_WAIT: if (scl) enter(PH_PRE_SDA_HOLD, 1'b1, 1'b0, hi);
			PH_PRE_SDA_HOLD: if (count_out()) enter(PH_PRE_LOW, 1'b0, 1'b0, lo);
			PH_PRE_LOW: if (count_out()) begin
				bit_cnt = '0;
				enter(PH_BIT_SETUP, 1'b0, slot_sda(), 16'd1);
			end
			PH_BIT_SETUP: if (count_out()) enter(PH_BIT_WAIT, 1'b1, sda_drv, '0);
			PH_BIT_WAIT: if (scl) enter(PH_BIT_HOLD, 1'b1, sda_drv, hi);
			PH_BIT_HOLD: if (count_out()) begin
				if (bit_cnt < 4'd8)
					shreg = {shreg[6:0], rd ? sda : 1'b0};
				else if (!rd)
					shreg = sda ? 8'h00 : 8'h01;
				enter(PH_BIT_LOW, 1'b0, sda_drv, lo);
			end
			PH_BIT_LOW: if (count_out()) begin
				if (bit_cnt >= 4'd8) begin
					ph = PH_IDLE;
					dly = '0;
					fin = 1'b1;
				end else begin
					bit_cnt = bit_cnt + 4'd1;
					enter(PH_BIT_SETUP, 1'b0, slot_sda(), 16'd1);
				end
			end
			PH_STOP_LOW: if (count_out()) enter(PH_STOP_WAIT, 1'b1, 1'b0, '0);
			PH_STOP_WAIT: if (scl) enter(PH_STOP_HOLD, 1'b1, 1'b0, hi);
			PH_STOP_HOLD: if (count_out()) enter(PH_STOP_REL_WAIT, 1'b1, 1'b1, '0);
			PH_STOP_REL_WAIT: if (scl) enter(PH_STOP_REL_HOLD, 1'b1, 1'b1, hi);
			PH_STOP_REL_HOLD: if (count_out()) begin
				ph = PH_IDLE;
				dly = '0;
				fin = 1'b1;
			end
			default: ph = PH_IDLE;
		endcase
		return fin;
	endfunction

	function automatic res_item_t bus_predict(cmd_item_t it);
		res_item_t r;
		bit fin;
		r = '0;
		fin = 1'b0;
		if (it.action == ACT_TICK) begin
			fin = bus_advance(it.scl_sample, it.sda_sample);
			if (fin) begin
				if (cur_cmd == ACT_READ)
					r.read_value = shreg;
				else if (cur_cmd != ACT_STOP)
					r.acked = shreg[0];
			end
		end else if (it.action <= ACT_READ) begin
			if (ph != PH_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				cur_cmd = it.action;
				bit_cnt = '0;
				if (it.action == ACT_START) begin
					shreg = {it.target_address, it.read_direction};
					enter(PH_PRE_REL_WAIT, 1'b1, 1'b1, '0);
				end else if (it.action == ACT_STOP) begin
					enter(PH_STOP_LOW, 1'b0, 1'b0, eff_ticks(low_ticks));
				end else begin
					shreg = (it.action == ACT_WRITE) ? it.write_value : 8'h00;
					ack_out = (it.action == ACT_READ) ? it.send_ack : 1'b0;
					enter(PH_BIT_SETUP, 1'b0, slot_sda(), 16'd1);
				end
			end
		end
		r.scl_release = scl_drv;
		r.sda_release = sda_drv;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = fin;
		return r;
	endfunction

	function automatic cmd_item_t make_cmd(logic [2:0] act);
		cmd_item_t t;
		logic [31:0] rnd;
		rnd = $urandom;
		t = rnd[$bits(cmd_item_t)-1:0];
		t.action = act;
		return t;
	endfunction

	// device side: may stretch SCL and pull SDA low whenever the master releases them
	function automatic cmd_item_t bus_tick();
		cmd_item_t t;
		t = make_cmd(ACT_TICK);
		if ($urandom_range(0, 11) != 0) begin
			t.scl_sample = scl_drv & ($urandom_range(0, 5) != 0);
			t.sda_sample = sda_drv & 1'($urandom_range(0, 1));
		end
		return t;
	endfunction

	function automatic logic [CFG_W-1:0] pick_ticks();
		return ($urandom_range(0, 9) < 8) ? CFG_W'($urandom_range(0, 2))
			: CFG_W'($urandom_range(3, 8));
	endfunction

	task automatic send_item(input cmd_item_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= it;
		do @(posedge clk); while (!cmd_ready);
		pending_status.push_back(bus_predict(it));
		item_cnt++;
	endtask

	task automatic finish_cmd();
		int r;
		while (ph != PH_IDLE) begin
			r = $urandom_range(0, 39);
			if (r == 0)
				send_item(make_cmd(3'($urandom_range(ACT_START, ACT_READ))));
			else if (r == 1)
				send_item(make_cmd(3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST))));
			else
				send_item(bus_tick());
		end
	endtask

	task automatic run_cmd(input cmd_item_t c);
		send_item(c);
		finish_cmd();
	endtask

	task automatic settle_idle();
		cmd_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_pair(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCL_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_SCL_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		low_ticks = lo;
		high_ticks = hi;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, res_item);
				err_cnt++;
			end else begin
				want = pending_status.pop_front();
				check_field("scl_release", 8'(want.scl_release), 8'(res_item.scl_release));
				check_field("sda_release", 8'(want.sda_release), 8'(res_item.sda_release));
				check_field("busy_res", 8'(want.busy_res), 8'(res_item.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(res_item.done_res));
				check_field("acked", 8'(want.acked), 8'(res_item.acked));
				check_field("read_value", want.read_value, res_item.read_value);
				check_field("rejected", 8'(want.rejected), 8'(res_item.rejected));
			end
			res_stall_cnt = quiet ? 0 : $urandom_range(0, 12);
			res_ready <= (res_stall_cnt == 0);
		end else if (res_stall_cnt > 0) begin
			res_stall_cnt--;
			if (res_stall_cnt == 0)
				res_ready <= 1'b1;
		end
	end

	task automatic test_idle_and_unknown();
		cmd_item_t c;
		int a;
		repeat (4) send_item(bus_tick());
		for (a = ACT_FIRST_UNUSED; a <= ACT_LAST; a++)
			send_item(make_cmd(3'(a)));
		run_cmd(make_cmd(ACT_STOP));
		c = make_cmd(ACT_START);
		c.target_address = 7'h00;
		c.read_direction = 1'b0;
		run_cmd(c);
		c = make_cmd(ACT_WRITE);
		c.write_value = 8'h00;
		run_cmd(c);
		run_cmd(make_cmd(ACT_STOP));
	endtask

	task automatic test_directed_commands();
		cmd_item_t c;
		settle_idle();
		cfg_pair('0, '0);
		c = make_cmd(ACT_START);
		c.target_address = 7'h7F;
		c.read_direction = 1'b1;
		send_item(c);
		send_item(make_cmd(ACT_WRITE));
		finish_cmd();
		c = make_cmd(ACT_READ);
		c.send_ack = 1'b1;
		run_cmd(c);
		c = make_cmd(ACT_READ);
		c.send_ack = 1'b0;
		run_cmd(c);
		c = make_cmd(ACT_START);
		c.target_address = 7'h55;
		c.read_direction = 1'b0;
		run_cmd(c);
		c = make_cmd(ACT_WRITE);
		c.write_value = 8'hFF;
		run_cmd(c);
		run_cmd(make_cmd(ACT_WRITE));
		run_cmd(make_cmd(ACT_STOP));
	endtask

	task automatic test_timing_extremes();
		settle_idle();
		quiet = 1'b1;
		cfg_pair(TICKS_LONG, TICKS_LONG);
		run_cmd(make_cmd(ACT_STOP));
		settle_idle();
		cfg_pair(CFG_W'(1), CFG_W'(1));
		run_cmd(make_cmd(ACT_START));
		run_cmd(make_cmd(ACT_STOP));
		quiet = 1'b0;
	endtask

	task automatic test_random_traffic();
		int kind;
		item_cnt = 0;
		while (item_cnt < RANDOM_ITEMS) begin
			settle_idle();
			cfg_pair(pick_ticks(), pick_ticks());
			quiet = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					repeat ($urandom_range(1, 8))
						send_item(make_cmd(3'($urandom_range(ACT_TICK, ACT_LAST))));
					finish_cmd();
				end else if (kind == 1) begin
					run_cmd(make_cmd(3'($urandom_range(ACT_STOP, ACT_READ))));
				end else begin
					run_cmd(make_cmd(ACT_START));
					repeat ($urandom_range(0, 3)) begin
						if ($urandom_range(0, 7) == 0)
							run_cmd(make_cmd(ACT_START));
						run_cmd(make_cmd($urandom_range(0, 1) ? ACT_WRITE : ACT_READ));
					end
					run_cmd(make_cmd(ACT_STOP));
				end
				repeat ($urandom_range(0, 3)) send_item(bus_tick());
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_unknown();
		test_directed_commands();
		test_timing_extremes();
		test_random_traffic();
		settle_idle();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
